>>> rtl/distinct_pointer_counter_core_assert.svh
// assertion macros for the distinct pointer counter
`ifndef DISTINCT_POINTER_COUNTER_CORE_ASSERT_SVH
`define DISTINCT_POINTER_COUNTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// clocked check, disabled while reset is asserted
`define DPC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define DPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DPC_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define DPC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/dpc_pkg.sv
package dpc_pkg;

  localparam int unsigned SLOTS        = 4096;
  localparam int unsigned DISTINCT_MAX = 2048;
  localparam int unsigned IdxW         = $clog2(SLOTS);

  localparam int unsigned AddrW = 64;
  localparam int unsigned NodeW = 32;
  localparam int unsigned DistW = 12;
  localparam int unsigned MulW  = 32;

  localparam int unsigned HashShift  = 48;
  localparam int unsigned AlignShift = 3;
  localparam logic [63:0] GoldenMult = 64'h9E37_79B9_7F4A_7C15;

  // request type codes
  localparam logic ReqNote     = 1'b0;
  localparam logic ReqFrameEnd = 1'b1;

  // one table entry
  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] addr;
  } slot_entry_t;

  // table port controls
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic            re;
    logic [IdxW-1:0] raddr;
  } slot_req_t;

endpackage

>>> rtl/dpc_hash.sv
module dpc_hash (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dpc_pkg::AddrW-1:0]  addr_i,
  output logic                       done_o,
  output logic [dpc_pkg::IdxW-1:0]   slot_o
);
  import dpc_pkg::*;

  // partial product sequence, low halves only where they reach bit 32 and up
  localparam logic [1:0] StepLoLo = 2'd0;
  localparam logic [1:0] StepLoHi = 2'd1;
  localparam logic [1:0] StepHiLo = 2'd2;
  localparam logic [1:0] StepLast = 2'd3;

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [1:0]       step_q, step_d;
  logic [AddrW-1:0] op_q;
  logic [2*MulW-1:0] p_q;
  logic [MulW-1:0]  acc_q;

  logic [MulW-1:0]   mul_a, mul_b;
  logic [2*MulW-1:0] prod;

  // the one shared multiplier
  assign mul_a = (step_q == StepHiLo) ? op_q[2*MulW-1:MulW] : op_q[MulW-1:0];
  assign mul_b = (step_q == StepLoHi) ? GoldenMult[2*MulW-1:MulW] : GoldenMult[MulW-1:0];
  assign prod  = mul_a * mul_b;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = StepLoLo;
    end else if (run_q) begin
      step_d = step_q + 2'd1;
      if (step_q == StepLast) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= StepLoLo;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q <= addr_i >> AlignShift;
    end
    if (run_q) begin
      p_q <= prod;
      if (step_q == StepLoHi) begin
        acc_q <= p_q[2*MulW-1:MulW];
      end else if (step_q == StepHiLo || step_q == StepLast) begin
        acc_q <= acc_q + p_q[MulW-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign slot_o = acc_q[HashShift-MulW +: IdxW];

endmodule

>>> rtl/dpc_slot_ram.sv
module dpc_slot_ram (
  input  logic                 clk_i,
  input  dpc_pkg::slot_req_t   req_i,
  input  dpc_pkg::slot_entry_t wdata_i,
  output dpc_pkg::slot_entry_t rdata_o
);
  import dpc_pkg::*;

  slot_entry_t mem_q [SLOTS];
  slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= wdata_i;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/distinct_pointer_counter_core.sv
// channel   | handshake          | payload
// ----------+--------------------+----------------------------------------------
// request   | start_i / busy_o   | req_type_i, list_address_i
// result    | done_o (strobe)    | node_count_o, distinct_count_o, was_new_o,
//           |                    | saturated_o
//
// a request transfers when start_i is high and busy_o is low
// a zero address or a note at the distinct limit answers next cycle, busy_o stays low
// other notes: hashing on the shared 32x32 multiplier, a table read, then a read per probe,
// with busy_o high from the transfer until the answer
// a frame end answers next cycle; reset and each frame end start a clearing pass over
// all 4096 entries, one entry per cycle with busy_o high; the receiver cannot stall
module distinct_pointer_counter_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic                      req_type_i,
  input  logic [dpc_pkg::AddrW-1:0] list_address_i,
  output logic                      done_o,
  output logic [dpc_pkg::NodeW-1:0] node_count_o,
  output logic [dpc_pkg::DistW-1:0] distinct_count_o,
  output logic                      was_new_o,
  output logic                      saturated_o
);
  import dpc_pkg::*;

  `include "distinct_pointer_counter_core_assert.svh"

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_READ  = 5'b01000,
    S_CMP   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // control state
  logic [NodeW-1:0] nodes_q, nodes_d;
  logic [DistW-1:0] distinct_q, distinct_d;
  logic [IdxW-1:0]  idx_q, idx_d;       // probe slot, doubles as clear pointer
  logic [IdxW-1:0]  probe_q, probe_d;   // probes already checked
  logic             done_q, done_d;

  // payload
  logic [AddrW-1:0] addr_q;
  logic [NodeW-1:0] res_node_q, res_node_d;
  logic [DistW-1:0] res_dist_q, res_dist_d;
  logic             res_new_q, res_new_d;
  logic             res_sat_q, res_sat_d;

  logic             accept;
  logic             hash_start;
  logic             hash_done;
  logic [IdxW-1:0]  hash_slot;
  slot_req_t        slot_req;
  slot_entry_t      slot_wdata;
  slot_entry_t      slot_rdata;

  logic [DistW-1:0] dist_plus;

  assign accept    = start_i && (state_q == S_IDLE);
  assign busy_o    = (state_q != S_IDLE);
  assign dist_plus = distinct_q + DistW'(1);

  always_comb begin
    state_d    = state_q;
    nodes_d    = nodes_q;
    distinct_d = distinct_q;
    idx_d      = idx_q;
    probe_d    = probe_q;
    done_d     = 1'b0;
    res_node_d = res_node_q;
    res_dist_d = res_dist_q;
    res_new_d  = 1'b0;
    res_sat_d  = res_sat_q;
    hash_start = 1'b0;
    slot_req   = '0;
    slot_wdata = '0;

    unique case (state_q)
      S_CLEAR: begin
        // drop the valid bit of one entry per cycle
        slot_req.we    = 1'b1;
        slot_req.waddr = idx_q;
        idx_d          = idx_q + IdxW'(1);
        if (idx_q == {IdxW{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (req_type_i == ReqFrameEnd) begin
            // report the frame, then wipe everything
            done_d     = 1'b1;
            res_node_d = nodes_q;
            res_dist_d = distinct_q;
            res_sat_d  = (distinct_q >= DistW'(DISTINCT_MAX));
            nodes_d    = '0;
            distinct_d = '0;
            idx_d      = '0;
            state_d    = S_CLEAR;
          end else begin
            nodes_d = nodes_q + NodeW'(1);
            if (list_address_i == '0 || distinct_q >= DistW'(DISTINCT_MAX)) begin
              // nothing to insert
              done_d     = 1'b1;
              res_node_d = nodes_q + NodeW'(1);
              res_dist_d = distinct_q;
              res_sat_d  = (distinct_q >= DistW'(DISTINCT_MAX));
            end else begin
              hash_start = 1'b1;
              state_d    = S_HASH;
            end
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          idx_d   = hash_slot;
          state_d = S_READ;
        end
      end
      S_READ: begin
        slot_req.re    = 1'b1;
        slot_req.raddr = idx_q;
        probe_d        = '0;
        state_d        = S_CMP;
      end
      S_CMP: begin
        res_node_d = nodes_q;
        if (!slot_rdata.valid) begin
          // empty slot takes the address
          slot_req.we      = 1'b1;
          slot_req.waddr   = idx_q;
          slot_wdata.valid = 1'b1;
          slot_wdata.addr  = addr_q;
          distinct_d       = dist_plus;
          done_d           = 1'b1;
          res_dist_d       = dist_plus;
          res_new_d        = 1'b1;
          res_sat_d        = (dist_plus >= DistW'(DISTINCT_MAX));
          state_d          = S_IDLE;
        end else if (slot_rdata.addr == addr_q || probe_q == {IdxW{1'b1}}) begin
          // hit, or every slot visited with the table full
          done_d     = 1'b1;
          res_dist_d = distinct_q;
          res_sat_d  = (distinct_q >= DistW'(DISTINCT_MAX));
          state_d    = S_IDLE;
        end else begin
          // linear probe, index wraps at the table size
          idx_d          = idx_q + IdxW'(1);
          probe_d        = probe_q + IdxW'(1);
          slot_req.re    = 1'b1;
          slot_req.raddr = idx_q + IdxW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      nodes_q    <= '0;
      distinct_q <= '0;
      idx_q      <= '0;
      probe_q    <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      nodes_q    <= nodes_d;
      distinct_q <= distinct_d;
      idx_q      <= idx_d;
      probe_q    <= probe_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_type_i == ReqNote) begin
      addr_q <= list_address_i;
    end
    res_node_q <= res_node_d;
    res_dist_q <= res_dist_d;
    res_new_q  <= res_new_d;
    res_sat_q  <= res_sat_d;
  end

  dpc_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .addr_i  (list_address_i),
    .done_o  (hash_done),
    .slot_o  (hash_slot)
  );

  dpc_slot_ram u_slot_ram (
    .clk_i   (clk_i),
    .req_i   (slot_req),
    .wdata_i (slot_wdata),
    .rdata_o (slot_rdata)
  );

  assign done_o           = done_q;
  assign node_count_o     = res_node_q;
  assign distinct_count_o = res_dist_q;
  assign was_new_o        = res_new_q && done_q;
  assign saturated_o      = res_sat_q;

  // the hash unit only finishes while the sequencer waits on it
  `DPC_ASSERT_RST(a_hash_done_in_hash, clk_i, rst_ni,
    hash_done |-> state_q == S_HASH,
    "hash done outside hash state")
  // a live entry is written only on a probe that found an empty slot
  `DPC_ASSERT_RST(a_insert_on_empty, clk_i, rst_ni,
    (slot_req.we && slot_wdata.valid) |-> (state_q == S_CMP && !slot_rdata.valid),
    "insert without empty slot")
  // the distinct count never passes its limit
  `DPC_ASSERT_RST(a_dist_bound, clk_i, rst_ni,
    distinct_q <= DistW'(DISTINCT_MAX),
    "distinct count over limit")
  // a fresh insert always moves the distinct count by one
  `DPC_ASSERT_RST(a_new_bumps, clk_i, rst_ni,
    was_new_o |-> distinct_q == $past(distinct_q) + DistW'(1) || $past(state_q) == S_CLEAR,
    "new address without count step")

endmodule
